// ===== rtl/rmq_pkg.sv =====
// rmq_pkg: shared widths, types and constants for the rotation matrix to quaternion block
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

    localparam int ELEM_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int NORM_BITS = 30;
    localparam int V_W       = ELEM_W + 3;
    localparam int MAG_W     = V_W - 1;
    localparam int SQR_W     = 2 * MAG_W;
    localparam int SUM_W     = SQR_W + 2;
    localparam int SQ_W      = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = NORM_BITS + 1;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SH_W      = $clog2(NORM_BITS + 1);
    localparam int LEN_W     = $clog2(MAG_W + 1);
    localparam int Q_W       = FRAC_BITS + 2;
    localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;

    localparam logic signed [V_W-1:0]    ONE_V = V_W'(1) << FRAC_BITS;
    localparam logic signed [ELEM_W-1:0] ONE_Q = ELEM_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_COL0,
        BR_COL1,
        BR_COL2
    } branch_t;

    typedef struct packed {
        logic [3:0] neg;
        branch_t    branch;
        logic       invalid;
    } tag_t;

    typedef struct packed {
        tag_t                       tag;
        logic [3:0][NORM_BITS-1:0]  mag;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/rmq_isqrt.sv =====
// rmq_isqrt: pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rmq_isqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [rmq_pkg::SQ_W-1:0]  x,
    input  wire rmq_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]     root,
    output rmq_pkg::side_t                 side_out
);
    import rmq_pkg::*;

    logic              valid_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SQ_W-1:0]   x_reg     [ROOT_W];
    side_t             side_reg  [ROOT_W];

    logic              valid_next [ROOT_W];
    logic [REM_W-1:0]  rem_next   [ROOT_W];
    logic [ROOT_W-1:0] root_next  [ROOT_W];
    logic [SQ_W-1:0]   x_next     [ROOT_W];
    side_t             side_next  [ROOT_W];

    logic [REM_W-1:0]  prem   [ROOT_W];
    logic [ROOT_W-1:0] proot  [ROOT_W];
    logic [SQ_W-1:0]   px     [ROOT_W];
    logic [REM_W-1:0]  rem_sh [ROOT_W];
    logic [REM_W-1:0]  trial  [ROOT_W];

    always_comb
    begin
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                valid_next[s] = in_valid;
                prem[s]       = '0;
                proot[s]      = '0;
                px[s]         = x;
                side_next[s]  = side_in;
            end
            else
            begin
                valid_next[s] = valid_reg[s-1];
                prem[s]       = rem_reg[s-1];
                proot[s]      = root_reg[s-1];
                px[s]         = x_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            rem_sh[s] = {prem[s][REM_W-3:0], px[s][SQ_W-1 -: 2]};
            trial[s]  = {proot[s], 2'b01};
            x_next[s] = px[s] << 2;
            if (rem_sh[s] >= trial[s])
            begin
                rem_next[s]  = rem_sh[s] - trial[s];
                root_next[s] = {proot[s][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_sh[s];
                root_next[s] = {proot[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ROOT_W; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            for (int s = 0; s < ROOT_W; s++)
                valid_reg[s] <= valid_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                x_reg[s]    <= x_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/rmq_div.sv =====
// rmq_div: four-lane pipelined restoring divider, one quotient bit per stage after the load stage
`timescale 1ns / 1ps
`default_nettype none
module rmq_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [rmq_pkg::ROOT_W-1:0]    n,
    input  wire rmq_pkg::side_t                side_in,
    output logic                               out_valid,
    output logic [3:0][rmq_pkg::Q_W-1:0]       quo,
    output rmq_pkg::tag_t                      tag_out
);
    import rmq_pkg::*;

    localparam int ST = Q_W + 1;

    logic                   valid_reg [ST];
    logic [3:0][ROOT_W-1:0] rem_reg   [ST];
    logic [3:0][Q_W-1:0]    lo_reg    [ST];
    logic [ROOT_W-1:0]      n_reg     [ST];
    tag_t                   tag_reg   [ST];

    logic [3:0][ROOT_W-1:0] rem_next  [ST];
    logic [3:0][Q_W-1:0]    lo_next   [ST];
    logic [3:0][NUM_W-1:0]  num;
    logic [3:0][ROOT_W:0]   rem_sh    [ST];
    logic [3:0]             ge        [ST];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            num[l] = (NUM_W'(side_in.mag[l]) << FRAC_BITS) + NUM_W'(n >> 1);
            rem_next[0][l] = ROOT_W'(num[l][NUM_W-1:Q_W]);
            lo_next[0][l]  = num[l][Q_W-1:0];
            rem_sh[0][l]   = '0;
            ge[0][l]       = 1'b0;
        end
        for (int s = 1; s < ST; s++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_sh[s][l] = {rem_reg[s-1][l], lo_reg[s-1][l][Q_W-1]};
                ge[s][l]     = rem_sh[s][l] >= {1'b0, n_reg[s-1]};
                if (ge[s][l])
                    rem_next[s][l] = ROOT_W'(rem_sh[s][l] - {1'b0, n_reg[s-1]});
                else
                    rem_next[s][l] = rem_sh[s][l][ROOT_W-1:0];
                lo_next[s][l] = {lo_reg[s-1][l][Q_W-2:0], ge[s][l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ST; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < ST; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= n;
            tag_reg[0] <= side_in.tag;
            for (int s = 1; s < ST; s++)
            begin
                n_reg[s]   <= n_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int s = 0; s < ST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
            end
        end
    end

    assign out_valid = valid_reg[ST-1];
    assign quo       = lo_reg[ST-1];
    assign tag_out   = tag_reg[ST-1];

endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// rotation_matrix_to_quaternion_top: rotation matrix to unit quaternion pipeline
// throughput: one matrix per cycle when not stalled; 3 prep stages, 31 root stages, 17 divide stages
// a stall on the output holds the whole pipeline in place
// reset clears only the valid bits; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m00,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m01,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m02,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m10,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m11,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m12,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m20,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m21,
    input  wire logic signed [rmq_pkg::ELEM_W-1:0]   m22,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [rmq_pkg::ELEM_W-1:0]        qw,
    output logic signed [rmq_pkg::ELEM_W-1:0]        qx,
    output logic signed [rmq_pkg::ELEM_W-1:0]        qy,
    output logic signed [rmq_pkg::ELEM_W-1:0]        qz,
    output logic [1:0]                               branch_taken,
    output logic                                     invalid
);
    import rmq_pkg::*;

    logic adv;

    // stage 1: branch select and vector
    logic signed [V_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [V_W-1:0] trace, r_val;
    logic signed [V_W-1:0] v_next [4];
    branch_t               br_next;

    logic                  s1_valid_reg;
    logic signed [V_W-1:0] s1_v_reg [4];
    branch_t               s1_br_reg;
    logic                  s1_inv_reg;

    // stage 2: magnitudes, normalize shift, squares
    logic [MAG_W-1:0]      mag_c [4];
    logic [3:0]            neg_c;
    logic [MAG_W-1:0]      or_all;
    logic [LEN_W-1:0]      len;

    logic                  s2_valid_reg;
    logic [MAG_W-1:0]      s2_mag_reg [4];
    logic [SQR_W-1:0]      s2_sq_reg  [4];
    logic [SH_W-1:0]       s2_k_reg;
    tag_t                  s2_tag_reg;

    // stage 3: sum of squares and shifted magnitudes
    logic [SUM_W-1:0]      sum_c;
    side_t                 side_c;

    logic                  s3_valid_reg;
    logic [SQ_W-1:0]       s3_x_reg;
    side_t                 s3_side_reg;

    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    side_t                 sq_side;

    logic                  dv_valid;
    logic [3:0][Q_W-1:0]   dv_quo;
    tag_t                  dv_tag;

    logic signed [Q_W:0]   qs [4];
    logic signed [ELEM_W-1:0] q_next [4];

    logic                  out_valid_reg;
    logic signed [ELEM_W-1:0] q_reg [4];
    branch_t               br_reg;
    logic                  inv_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        e00 = V_W'(m00);
        e01 = V_W'(m01);
        e02 = V_W'(m02);
        e10 = V_W'(m10);
        e11 = V_W'(m11);
        e12 = V_W'(m12);
        e20 = V_W'(m20);
        e21 = V_W'(m21);
        e22 = V_W'(m22);
        trace = e00 + e11 + e22;
        if (trace > 0)
        begin
            br_next   = BR_TRACE;
            r_val     = ONE_V + trace;
            v_next[0] = r_val;
            v_next[1] = e21 - e12;
            v_next[2] = e02 - e20;
            v_next[3] = e10 - e01;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            br_next   = BR_COL0;
            r_val     = ONE_V + e00 - e11 - e22;
            v_next[0] = e21 - e12;
            v_next[1] = r_val;
            v_next[2] = e10 + e01;
            v_next[3] = e02 + e20;
        end
        else if (e11 > e22)
        begin
            br_next   = BR_COL1;
            r_val     = ONE_V + e11 - e00 - e22;
            v_next[0] = e02 - e20;
            v_next[1] = e10 + e01;
            v_next[2] = r_val;
            v_next[3] = e21 + e12;
        end
        else
        begin
            br_next   = BR_COL2;
            r_val     = ONE_V + e22 - e00 - e11;
            v_next[0] = e10 - e01;
            v_next[1] = e02 + e20;
            v_next[2] = e21 + e12;
            v_next[3] = r_val;
        end
    end

    always_comb
    begin
        or_all = '0;
        len    = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg_c[i] = s1_v_reg[i][V_W-1];
            mag_c[i] = neg_c[i] ? MAG_W'(-s1_v_reg[i]) : MAG_W'(s1_v_reg[i]);
            or_all   = or_all | mag_c[i];
        end
        for (int b = 0; b < MAG_W; b++)
        begin
            if (or_all[b])
                len = LEN_W'(b + 1);
        end
    end

    always_comb
    begin
        sum_c = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1])
              + SUM_W'(s2_sq_reg[2]) + SUM_W'(s2_sq_reg[3]);
        side_c.tag = s2_tag_reg;
        for (int i = 0; i < 4; i++)
            side_c.mag[i] = NORM_BITS'(s2_mag_reg[i]) << s2_k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_v_reg[i]   <= v_next[i];
                s2_mag_reg[i] <= mag_c[i];
                s2_sq_reg[i]  <= mag_c[i] * mag_c[i];
            end
            s1_br_reg          <= br_next;
            s1_inv_reg         <= (r_val <= 0);
            s2_k_reg           <= SH_W'(NORM_BITS - int'(len));
            s2_tag_reg.neg     <= neg_c;
            s2_tag_reg.branch  <= s1_br_reg;
            s2_tag_reg.invalid <= s1_inv_reg;
            s3_x_reg           <= SQ_W'(sum_c) << {s2_k_reg, 1'b0};
            s3_side_reg        <= side_c;
        end
    end

    rmq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .x         (s3_x_reg),
        .side_in   (s3_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .n         (sq_root),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .tag_out   (dv_tag)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qs[i] = dv_tag.neg[i] ? -$signed({1'b0, dv_quo[i]}) : $signed({1'b0, dv_quo[i]});
            q_next[i] = dv_tag.invalid ? '0 : ELEM_W'(qs[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                q_reg[i] <= q_next[i];
            br_reg  <= dv_tag.branch;
            inv_reg <= dv_tag.invalid;
        end
    end

    assign out_valid    = out_valid_reg;
    assign qw           = q_reg[0];
    assign qx           = q_reg[1];
    assign qy           = q_reg[2];
    assign qz           = q_reg[3];
    assign branch_taken = br_reg;
    assign invalid      = inv_reg;

    // invalid result carries a zero quaternion
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
        else $error("invalid result with nonzero quaternion");

    // trace branch always has a positive radicand
    a_trace_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && br_reg == BR_TRACE |-> !invalid)
        else $error("trace branch flagged invalid");

    // unit quaternion parts stay within one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid |-> qw <= ONE_Q && qw >= -ONE_Q && qx <= ONE_Q
            && qx >= -ONE_Q && qy <= ONE_Q && qy >= -ONE_Q && qz <= ONE_Q && qz >= -ONE_Q)
        else $error("quaternion part out of range");

    // a valid result is never the zero quaternion
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid |-> qw != 0 || qx != 0 || qy != 0 || qz != 0)
        else $error("valid result is zero quaternion");

endmodule
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_top_test.sv =====
// testbench for the rotation matrix to quaternion block: random and directed matrices against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top_test;
    import rmq_pkg::*;

    typedef struct {
        logic signed [ELEM_W-1:0] m [9];
    } matrix_t;

    typedef struct {
        logic [ELEM_W-1:0] q [4];
        branch_t           br;
        logic              inv;
    } quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic out_valid;
    logic out_ready;
    logic signed [ELEM_W-1:0] qw, qx, qy, qz;
    logic [1:0] branch_taken;
    logic invalid;

    matrix_t pending_matrices[$];
    quat_t   expected_quats[$];
    int      error_count;
    int      src_idle_pct;
    int      snk_idle_pct;
    bit      long_hold;
    bit      stimulus_done;
    bit      in_taken;

    rotation_matrix_to_quaternion_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .out_valid(out_valid), .out_ready(out_ready),
        .qw(qw), .qx(qx), .qy(qy), .qz(qz),
        .branch_taken(branch_taken), .invalid(invalid)
    );

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic quat_t matrix_to_quat(matrix_t mt);
        quat_t r;
        longint a [9];
        longint v [4];
        longint rad;
        longint unsigned mag [4];
        longint unsigned big, sumsq, n, qq;
        int len;
        for (int i = 0; i < 9; i++)
            a[i] = mt.m[i];
        if (a[0] + a[4] + a[8] > 0)
        begin
            r.br = BR_TRACE;
            rad = (1 << FRAC_BITS) + a[0] + a[4] + a[8];
            v = '{rad, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            r.br = BR_COL0;
            rad = (1 << FRAC_BITS) + a[0] - a[4] - a[8];
            v = '{a[7] - a[5], rad, a[3] + a[1], a[2] + a[6]};
        end
        else if (a[4] > a[8])
        begin
            r.br = BR_COL1;
            rad = (1 << FRAC_BITS) + a[4] - a[0] - a[8];
            v = '{a[2] - a[6], a[3] + a[1], rad, a[7] + a[5]};
        end
        else
        begin
            r.br = BR_COL2;
            rad = (1 << FRAC_BITS) + a[8] - a[0] - a[4];
            v = '{a[3] - a[1], a[2] + a[6], a[7] + a[5], rad};
        end
        r.inv = (rad <= 0);
        r.q = '{default: '0};
        if (r.inv)
            return r;
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > big)
                big = mag[i];
        end
        len = 0;
        while (big != 0)
        begin
            len++;
            big >>= 1;
        end
        sumsq = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (len > NORM_BITS)
                mag[i] >>= (len - NORM_BITS);
            else
                mag[i] <<= (NORM_BITS - len);
            sumsq += mag[i] * mag[i];
        end
        n = int_sqrt(sumsq);
        for (int i = 0; i < 4; i++)
        begin
            qq = ((mag[i] << FRAC_BITS) + (n >> 1)) / n;
            r.q[i] = v[i] < 0 ? ELEM_W'(-qq) : ELEM_W'(qq);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return ELEM_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            default: return ELEM_W'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // random rotation from a random unit-ish quaternion, plus small noise
    function automatic matrix_t rand_rotation();
        matrix_t mt;
        real w, x, y, z, nn;
        real rm [9];
        w = $urandom_range(0, 2000) - 1000.0;
        x = $urandom_range(0, 2000) - 1000.0;
        y = $urandom_range(0, 2000) - 1000.0;
        z = $urandom_range(0, 2000) - 1000.0;
        nn = w * w + x * x + y * y + z * z + 1.0;
        rm = '{1 - 2 * (y * y + z * z) / nn, 2 * (x * y - z * w) / nn, 2 * (x * z + y * w) / nn,
               2 * (x * y + z * w) / nn, 1 - 2 * (x * x + z * z) / nn, 2 * (y * z - x * w) / nn,
               2 * (x * z - y * w) / nn, 2 * (y * z + x * w) / nn, 1 - 2 * (x * x + y * y) / nn};
        for (int i = 0; i < 9; i++)
            mt.m[i] = ELEM_W'($rtoi(rm[i] * 16384.0) + $signed($urandom_range(0, 6)) - 3);
        return mt;
    endfunction

    task automatic add_matrix(matrix_t mt);
        pending_matrices.push_back(mt);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("[rotation_matrix_to_quaternion_top] ERROR");
        $finish;
    end

    // receiver hold-off stretch
    initial
    begin
        wait (long_hold);
        repeat (300) @(posedge clk);
        @(negedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk)
        in_taken <= rst_n && in_valid && in_ready;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_matrices.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                matrix_t mt;
                mt = pending_matrices.pop_front();
                {m00, m01, m02, m10, m11, m12, m20, m21, m22} =
                    {mt.m[0], mt.m[1], mt.m[2], mt.m[3], mt.m[4], mt.m[5],
                     mt.m[6], mt.m[7], mt.m[8]};
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ready <= !long_hold && $urandom_range(0, 99) >= snk_idle_pct;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_quats.push_back(matrix_to_quat('{m:
                '{m00, m01, m02, m10, m11, m12, m20, m21, m22}}));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                $display("unexpected result transfer");
                error_count++;
            end
            else
            begin
                quat_t e;
                e = expected_quats.pop_front();
                if (qw !== e.q[0]) report_mismatch("qw", qw, $signed(e.q[0]));
                if (qx !== e.q[1]) report_mismatch("qx", qx, $signed(e.q[1]));
                if (qy !== e.q[2]) report_mismatch("qy", qy, $signed(e.q[2]));
                if (qz !== e.q[3]) report_mismatch("qz", qz, $signed(e.q[3]));
                if (branch_taken !== e.br) report_mismatch("branch", branch_taken, e.br);
                if (invalid !== e.inv) report_mismatch("invalid", invalid, e.inv);
            end
        end
    end

    initial
    begin
        matrix_t mt;
        error_count = 0;
        src_idle_pct = 14;
        snk_idle_pct = 82;
        long_hold = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, each axis flip, all-min, all-max, ties, negative diagonals
        add_matrix('{m: '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}});
        add_matrix('{m: '{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q}});
        add_matrix('{m: '{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q}});
        add_matrix('{m: '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q}});
        add_matrix('{m: '{default: 16'sh8000}});
        add_matrix('{m: '{default: 16'sh7fff}});
        add_matrix('{m: '{default: 16'sh0000}});
        add_matrix('{m: '{default: -16'sd1}});
        add_matrix('{m: '{-100, 0, 0, 0, -100, 0, 0, 0, -100}});
        add_matrix('{m: '{-8192, 7, 9, 11, -8192, 13, 15, 17, 16384}});
        add_matrix('{m: '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}});
        add_matrix('{m: '{16'sh8000, 5, 6, 7, 16'sh7fff, 8, 9, 10, 16'sh7fff}});
        add_matrix('{m: '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7fff}});
        add_matrix('{m: '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}});
        add_matrix('{m: '{16'sh7fff, 1, 2, 3, 16'sh7fff, 4, 5, 6, 16'sh8000}});
        add_matrix('{m: '{-30000, 1, 1, 1, -30000, 1, 1, 1, 16'sh8000}});
        add_matrix('{m: '{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q}});
        add_matrix('{m: '{-1, 0, 0, 0, 0, 0, 0, 0, 0}});
        for (int i = 0; i < 1750; i++)
        begin
            if (i == 580)
            begin
                wait (pending_matrices.size() == 0 && expected_quats.size() == 0);
                src_idle_pct = 82;
                snk_idle_pct = 14;
            end
            if (i == 1160)
            begin
                wait (pending_matrices.size() == 0 && expected_quats.size() == 0);
                src_idle_pct = 0;
                snk_idle_pct = 0;
                long_hold = 1'b1;
            end
            if ($urandom_range(0, 99) < 70)
                mt = rand_rotation();
            else
                for (int k = 0; k < 9; k++)
                    mt.m[k] = rand_elem();
            add_matrix(mt);
        end
        wait (pending_matrices.size() == 0 && !in_valid);
        wait (expected_quats.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("[rotation_matrix_to_quaternion_top] OK");
        else
            $display("[rotation_matrix_to_quaternion_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
